[design/sclru_pkg.sv]
// types and constants shared by the sector cache lru controller
`timescale 1ns / 1ps
package sclru_pkg;

    // request codes
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FLUSH = 2'd2,
        OP_RESET = 2'd3
    } op_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_FLUSH_END
    } state_t;

    // width of the per-slot use stamp, wide enough never to wrap in practice
    localparam int STAMP_BITS   = 48;
    // most flush transactions reported by one request
    localparam int MAX_RESULTS  = 64;
    localparam int RES_CNT_BITS = 7;

    // one result transaction
    typedef struct packed {
        logic [5:0]  slot;
        logic        hit;
        logic        fill_needed;
        logic        writeback_needed;
        logic [31:0] writeback_sector;
        logic        last;
        logic [31:0] hit_count;
        logic [31:0] access_count;
    } result_t;

endpackage

[design/sclru_store.sv]
// slot store memory: tag, dirty mark and use stamp per slot
`timescale 1ns / 1ps
module sclru_store #(
    parameter int ENTRIES = 64,
    parameter int ROW_W   = 81
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(ENTRIES)-1:0] waddr,
    input  logic [ROW_W-1:0]           wdata,
    input  logic                       re,
    input  logic [$clog2(ENTRIES)-1:0] raddr,
    output logic [ROW_W-1:0]           rdata
);
    logic [ROW_W-1:0] mem [ENTRIES];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[design/sclru_ctrl.sv]
// sequencer: scans the slot store, decides hit, fill or eviction, runs flush
`timescale 1ns / 1ps
module sclru_ctrl #(
    parameter int ENTRIES     = 64,
    parameter int SECTOR_BITS = 32,
    parameter int ROW_W       = 81
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [1:0]                 op_in,
    input  logic [31:0]                sector_in,
    output logic                       busy,
    output logic                       mem_we,
    output logic [$clog2(ENTRIES)-1:0] mem_waddr,
    output logic [ROW_W-1:0]           mem_wdata,
    output logic                       mem_re,
    output logic [$clog2(ENTRIES)-1:0] mem_raddr,
    input  logic [ROW_W-1:0]           mem_rdata,
    output logic                       res_valid,
    output sclru_pkg::result_t         res
);
    import sclru_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = AW + 1;

    state_t                 state_reg, state_next;
    op_t                    op_reg, op_next;
    logic [SECTOR_BITS-1:0] sector_reg, sector_next;
    logic [CW-1:0]          filled_reg, filled_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic [AW-1:0]          rd_idx_reg, rd_idx_next;
    logic                   hit_found_reg, hit_found_next;
    logic [AW-1:0]          hit_slot_reg, hit_slot_next;
    logic                   hit_dirty_reg, hit_dirty_next;
    logic                   min_valid_reg, min_valid_next;
    logic [AW-1:0]          min_slot_reg, min_slot_next;
    logic [SECTOR_BITS-1:0] min_tag_reg, min_tag_next;
    logic                   min_dirty_reg, min_dirty_next;
    logic [STAMP_BITS-1:0]  min_stamp_reg, min_stamp_next;
    logic [STAMP_BITS-1:0]  stamp_reg, stamp_next;
    logic [31:0]            hits_reg, hits_next;
    logic [31:0]            acc_reg, acc_next;
    logic [RES_CNT_BITS-1:0] nres_reg, nres_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [AW-1:0]          pend_slot_reg, pend_slot_next;
    logic [SECTOR_BITS-1:0] pend_tag_reg, pend_tag_next;

    logic [SECTOR_BITS-1:0]    rd_tag;
    logic                      rd_dirty;
    logic [STAMP_BITS-1:0]     rd_stamp;
    logic [SECTOR_BITS+31:0]   sector_ext;
    logic                      is_access;
    logic                      is_write;
    logic                      last_issue;

    // zero-extend or truncate a slot index to the result field
    function automatic logic [5:0] slot_out(input logic [AW-1:0] s);
        logic [AW+5:0] t;
        t = {6'b0, s};
        return t[5:0];
    endfunction

    // zero-extend or truncate a stored sector to the result field
    function automatic logic [31:0] sec_out(input logic [SECTOR_BITS-1:0] s);
        logic [SECTOR_BITS+31:0] t;
        t = {32'b0, s};
        return t[31:0];
    endfunction

    // row fields
    assign rd_tag     = mem_rdata[ROW_W-1 -: SECTOR_BITS];
    assign rd_dirty   = mem_rdata[STAMP_BITS];
    assign rd_stamp   = mem_rdata[STAMP_BITS-1:0];
    assign sector_ext = {{SECTOR_BITS{1'b0}}, sector_in};
    assign is_access  = (op_reg == OP_READ) || (op_reg == OP_WRITE);
    assign is_write   = (op_reg == OP_WRITE);
    assign last_issue = (CW'(idx_reg) + CW'(1)) == filled_reg;
    assign busy       = (state_reg != ST_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (filled_reg == '0)
                    begin
                        if ((op_in == OP_READ) || (op_in == OP_WRITE))
                        begin
                            state_next = ST_DECIDE;
                        end
                        else
                        begin
                            state_next = ST_FLUSH_END;
                        end
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = is_access ? ST_DECIDE : ST_FLUSH_END;
            end
            ST_DECIDE:    state_next = ST_IDLE;
            ST_FLUSH_END: state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath, memory accesses and result transactions
    always_comb
    begin
        op_next         = op_reg;
        sector_next     = sector_reg;
        filled_next     = filled_reg;
        idx_next        = idx_reg;
        rd_pend_next    = rd_pend_reg;
        rd_idx_next     = rd_idx_reg;
        hit_found_next  = hit_found_reg;
        hit_slot_next   = hit_slot_reg;
        hit_dirty_next  = hit_dirty_reg;
        min_valid_next  = min_valid_reg;
        min_slot_next   = min_slot_reg;
        min_tag_next    = min_tag_reg;
        min_dirty_next  = min_dirty_reg;
        min_stamp_next  = min_stamp_reg;
        stamp_next      = stamp_reg;
        hits_next       = hits_reg;
        acc_next        = acc_reg;
        nres_next       = nres_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_tag_next   = pend_tag_reg;
        mem_we          = 1'b0;
        mem_waddr       = rd_idx_reg;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = idx_reg;
        res_valid       = 1'b0;
        res             = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next         = op_t'(op_in);
                    sector_next     = sector_ext[SECTOR_BITS-1:0];
                    idx_next        = '0;
                    rd_pend_next    = 1'b0;
                    hit_found_next  = 1'b0;
                    min_valid_next  = 1'b0;
                    nres_next       = '0;
                    pend_valid_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                mem_re       = 1'b1;
                rd_pend_next = 1'b1;
                rd_idx_next  = idx_reg;
                idx_next     = idx_reg + AW'(1);
            end
            ST_DRAIN:
            begin
                rd_pend_next = 1'b0;
            end
            ST_DECIDE:
            begin
                acc_next             = acc_reg + 32'd1;
                stamp_next           = stamp_reg + STAMP_BITS'(1);
                mem_we               = 1'b1;
                res_valid            = 1'b1;
                res.last             = 1'b1;
                res.access_count     = acc_reg + 32'd1;
                res.hit_count        = hits_reg;
                if (hit_found_reg)
                begin
                    hits_next     = hits_reg + 32'd1;
                    res.hit_count = hits_reg + 32'd1;
                    mem_waddr     = hit_slot_reg;
                    mem_wdata     = {sector_reg, hit_dirty_reg | is_write, stamp_reg};
                    res.slot      = slot_out(hit_slot_reg);
                    res.hit       = 1'b1;
                end
                else
                begin
                    mem_wdata       = {sector_reg, is_write, stamp_reg};
                    res.fill_needed = ~is_write;
                    if (filled_reg < CW'(ENTRIES))
                    begin
                        // take the next empty slot
                        mem_waddr   = filled_reg[AW-1:0];
                        filled_next = filled_reg + CW'(1);
                        res.slot    = slot_out(filled_reg[AW-1:0]);
                    end
                    else
                    begin
                        // evict the least recently used slot
                        mem_waddr            = min_slot_reg;
                        res.slot             = slot_out(min_slot_reg);
                        res.writeback_needed = min_dirty_reg;
                        res.writeback_sector = min_dirty_reg ? sec_out(min_tag_reg) : 32'd0;
                    end
                end
            end
            ST_FLUSH_END:
            begin
                if (pend_valid_reg)
                begin
                    res_valid            = 1'b1;
                    res.slot             = slot_out(pend_slot_reg);
                    res.writeback_needed = 1'b1;
                    res.writeback_sector = sec_out(pend_tag_reg);
                    res.last             = 1'b1;
                    res.hit_count        = hits_reg;
                    res.access_count     = acc_reg;
                end
                pend_valid_next = 1'b0;
                if (op_reg == OP_RESET)
                begin
                    filled_next = '0;
                    hits_next   = '0;
                    acc_next    = '0;
                end
            end
            default:
            begin
            end
        endcase

        // handle the row read in the previous cycle
        if (rd_pend_reg)
        begin
            if (is_access)
            begin
                if (!hit_found_reg && (rd_tag == sector_reg))
                begin
                    hit_found_next = 1'b1;
                    hit_slot_next  = rd_idx_reg;
                    hit_dirty_next = rd_dirty;
                end
                if (!min_valid_reg || (rd_stamp < min_stamp_reg))
                begin
                    min_valid_next = 1'b1;
                    min_slot_next  = rd_idx_reg;
                    min_tag_next   = rd_tag;
                    min_dirty_next = rd_dirty;
                    min_stamp_next = rd_stamp;
                end
            end
            else if (rd_dirty && (nres_reg < RES_CNT_BITS'(MAX_RESULTS)))
            begin
                // clean the slot and hold it back until the next one shows
                mem_we    = 1'b1;
                mem_waddr = rd_idx_reg;
                mem_wdata = {rd_tag, 1'b0, rd_stamp};
                if (pend_valid_reg)
                begin
                    res_valid            = 1'b1;
                    res.slot             = slot_out(pend_slot_reg);
                    res.writeback_needed = 1'b1;
                    res.writeback_sector = sec_out(pend_tag_reg);
                    res.last             = 1'b0;
                    res.hit_count        = hits_reg;
                    res.access_count     = acc_reg;
                end
                pend_valid_next = 1'b1;
                pend_slot_next  = rd_idx_reg;
                pend_tag_next   = rd_tag;
                nres_next       = nres_reg + RES_CNT_BITS'(1);
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            filled_reg     <= '0;
            rd_pend_reg    <= 1'b0;
            stamp_reg      <= '0;
            hits_reg       <= '0;
            acc_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            filled_reg     <= filled_next;
            rd_pend_reg    <= rd_pend_next;
            stamp_reg      <= stamp_next;
            hits_reg       <= hits_next;
            acc_reg        <= acc_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        sector_reg     <= sector_next;
        idx_reg        <= idx_next;
        rd_idx_reg     <= rd_idx_next;
        hit_found_reg  <= hit_found_next;
        hit_slot_reg   <= hit_slot_next;
        hit_dirty_reg  <= hit_dirty_next;
        min_valid_reg  <= min_valid_next;
        min_slot_reg   <= min_slot_next;
        min_tag_reg    <= min_tag_next;
        min_dirty_reg  <= min_dirty_next;
        min_stamp_reg  <= min_stamp_next;
        nres_reg       <= nres_next;
        pend_slot_reg  <= pend_slot_next;
        pend_tag_reg   <= pend_tag_next;
    end
endmodule

[design/sector_cache_lru_controller_core.sv]
// top level of the sector cache lru controller
//
//   channel   | ports                                       | handshake
//   ----------+---------------------------------------------+-------------------------
//   request   | op, sector                                  | start while busy is low
//   result    | slot, hit, fill_needed, writeback_needed,   | done, one cycle, no stall
//             | writeback_sector, last, hit_count,          |
//             | access_count                                |
//
// a read or write reads the filled slots one per cycle from the slot store, then
// decides and writes the chosen row back; with an empty cache it skips the scan.
// a flush reads the filled slots the same way; its transactions come out while the
// scan runs, and the held-back last one when the flush ends.
// a flush of an empty cache gives no transaction.
// reset flushes, then clears the counters and empties the cache; no clearing pass.
// results cannot be stalled; busy stays high until the request is finished.
`timescale 1ns / 1ps
module sector_cache_lru_controller_core #(
    parameter int ENTRIES     = 64,
    parameter int SECTOR_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [31:0] sector,
    output logic        done,
    output logic [5:0]  slot,
    output logic        hit,
    output logic        fill_needed,
    output logic        writeback_needed,
    output logic [31:0] writeback_sector,
    output logic        last,
    output logic [31:0] hit_count,
    output logic [31:0] access_count
);
    import sclru_pkg::*;

    localparam int AW    = $clog2(ENTRIES);
    localparam int ROW_W = SECTOR_BITS + 1 + STAMP_BITS;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [ROW_W-1:0] mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [ROW_W-1:0] mem_rdata;
    logic             res_valid;
    result_t          res;
    logic             done_reg;
    result_t          res_reg;

    // slot store
    sclru_store #(
        .ENTRIES (ENTRIES),
        .ROW_W   (ROW_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // sequencer
    sclru_ctrl #(
        .ENTRIES     (ENTRIES),
        .SECTOR_BITS (SECTOR_BITS),
        .ROW_W       (ROW_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .op_in     (op),
        .sector_in (sector),
        .busy      (busy),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res       (res)
    );

    // result output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign done             = done_reg;
    assign slot             = res_reg.slot;
    assign hit              = res_reg.hit;
    assign fill_needed      = res_reg.fill_needed;
    assign writeback_needed = res_reg.writeback_needed;
    assign writeback_sector = res_reg.writeback_sector;
    assign last             = res_reg.last;
    assign hit_count        = res_reg.hit_count;
    assign access_count     = res_reg.access_count;
endmodule

[design/sclru_checker.sv]
// port-level checks for the sector cache lru controller
`timescale 1ns / 1ps
module sclru_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        hit,
    input logic        fill_needed,
    input logic        writeback_needed,
    input logic [31:0] writeback_sector,
    input logic        last
);
    // an accepted request always raises busy
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted request");

    // a hit is a single final transaction that needs no disk traffic
    a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (!fill_needed && !writeback_needed && last))
        else $error("hit transaction with fill or writeback");

    // no writeback means no sector to write
    a_wb_sector_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !writeback_needed) |-> (writeback_sector == 32'd0))
        else $error("writeback sector set without writeback");

    // more transactions are still coming, so the request is not finished
    a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !last) |-> busy)
        else $error("non-final transaction while idle");
endmodule

bind sector_cache_lru_controller_core sclru_checker u_sclru_checker (.*);

[dv/tb.sv]
// testbench for the sector cache lru controller: directed and random requests checked against a predictor
`timescale 1ns / 1ps
module tb;
    import sclru_pkg::*;

    localparam int SLOTS      = 64;
    localparam int WDOG_LIMIT = 20000;
    localparam int DRAIN_WAIT = 300;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  op;
    logic [31:0] sector;
    logic        done;
    logic [5:0]  slot;
    logic        hit;
    logic        fill_needed;
    logic        writeback_needed;
    logic [31:0] writeback_sector;
    logic        last;
    logic [31:0] hit_count;
    logic [31:0] access_count;

    int          fail_count;
    int          quiet_cycles;
    int          send_idle_pct;
    logic [31:0] sector_pool[16];

    sector_cache_lru_controller_core i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .op               (op),
        .sector           (sector),
        .done             (done),
        .slot             (slot),
        .hit              (hit),
        .fill_needed      (fill_needed),
        .writeback_needed (writeback_needed),
        .writeback_sector (writeback_sector),
        .last             (last),
        .hit_count        (hit_count),
        .access_count     (access_count)
    );

    // mismatch report
    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    // cache bookkeeping model and queue of expected transactions
    class cache_scoreboard;
        logic [31:0] tags[SLOTS];
        bit          dirty[SLOTS];
        int          filled;
        int          lru_list[$];
        logic [31:0] hits;
        logic [31:0] accesses;
        result_t     pending[$];

        function void clear();
            filled   = 0;
            lru_list = {};
            hits     = '0;
            accesses = '0;
            foreach (dirty[i]) dirty[i] = 0;
        endfunction

        function void push(int s, bit h, bit f, bit w, logic [31:0] ws, bit l);
            result_t r;
            r.slot             = s[5:0];
            r.hit              = h;
            r.fill_needed      = f;
            r.writeback_needed = w;
            r.writeback_sector = w ? ws : '0;
            r.last             = l;
            r.hit_count        = hits;
            r.access_count     = accesses;
            pending.push_back(r);
        endfunction

        // report every dirty filled slot and clean it
        function void flush_dirty();
            int n;
            n = 0;
            for (int i = 0; i < filled; i++)
            begin
                if (dirty[i])
                begin
                    dirty[i] = 0;
                    push(i, 0, 0, 1, tags[i], 0);
                    n++;
                end
            end
            if (n > 0) pending[pending.size() - 1].last = 1'b1;
        endfunction

        function void lookup(bit is_write, logic [31:0] sec);
            int victim;
            bit wb;
            logic [31:0] wb_sec;
            accesses++;
            for (int i = 0; i < filled; i++)
            begin
                if (tags[i] == sec)
                begin
                    foreach (lru_list[p])
                        if (lru_list[p] == i)
                        begin
                            lru_list.delete(p);
                            break;
                        end
                    lru_list.push_back(i);
                    if (is_write) dirty[i] = 1;
                    hits++;
                    push(i, 1, 0, 0, '0, 1);
                    return;
                end
            end
            wb     = 0;
            wb_sec = '0;
            if (filled < SLOTS)
            begin
                victim = filled;
                lru_list.push_back(victim);
                filled++;
            end
            else
            begin
                victim = lru_list.pop_front();
                lru_list.push_back(victim);
                if (dirty[victim])
                begin
                    wb     = 1;
                    wb_sec = tags[victim];
                end
            end
            tags[victim]  = sec;
            dirty[victim] = is_write;
            push(victim, 0, !is_write, wb, wb_sec, 1);
        endfunction

        function void note_request(op_t code, logic [31:0] sec);
            case (code)
                OP_READ:  lookup(0, sec);
                OP_WRITE: lookup(1, sec);
                OP_FLUSH: flush_dirty();
                default:
                begin
                    flush_dirty();
                    clear();
                end
            endcase
        endfunction

        task check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                report("unexpected transaction slot", 32'(got.slot), 32'd0);
                return;
            end
            want = pending.pop_front();
            if (got.slot != want.slot) report("slot", 32'(got.slot), 32'(want.slot));
            if (got.hit != want.hit) report("hit", 32'(got.hit), 32'(want.hit));
            if (got.fill_needed != want.fill_needed)
                report("fill_needed", 32'(got.fill_needed), 32'(want.fill_needed));
            if (got.writeback_needed != want.writeback_needed)
                report("writeback_needed", 32'(got.writeback_needed),
                       32'(want.writeback_needed));
            if (got.writeback_sector != want.writeback_sector)
                report("writeback_sector", got.writeback_sector, want.writeback_sector);
            if (got.last != want.last) report("last", 32'(got.last), 32'(want.last));
            if (got.hit_count != want.hit_count)
                report("hit_count", got.hit_count, want.hit_count);
            if (got.access_count != want.access_count)
                report("access_count", got.access_count, want.access_count);
        endtask
    endclass

    cache_scoreboard board;

    // clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // result monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                result_t r;
                r.slot             = slot;
                r.hit              = hit;
                r.fill_needed      = fill_needed;
                r.writeback_needed = writeback_needed;
                r.writeback_sector = writeback_sector;
                r.last             = last;
                r.hit_count        = hit_count;
                r.access_count     = access_count;
                board.check_result(r);
            end
            if (done || (start && !busy))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // send one request transaction, with a random gap ahead of it
    task automatic send_request(input op_t code, input logic [31:0] sec);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        start  <= 1'b1;
        op     <= code;
        sector <= sec;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_request(code, sec);
        start <= 1'b0;
        op    <= 2'($urandom);
        // the block is busy in the next cycle anyway
        @(posedge clk);
    endtask

    // random sector, mostly from a small pool so hits and evictions happen
    function automatic logic [31:0] pick_sector();
        if ($urandom_range(99) < 70)
            return sector_pool[$urandom_range(15)];
        return $urandom;
    endfunction

    // random request mix: mostly reads and writes, few flushes and resets
    task automatic random_phase(input int count, input int idle_pct);
        int pick;
        send_idle_pct = idle_pct;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                send_request(OP_READ, pick_sector());
            else if (pick < 92)
                send_request(OP_WRITE, pick_sector());
            else if (pick < 97)
                send_request(OP_FLUSH, $urandom);
            else
                send_request(OP_RESET, $urandom);
        end
    endtask

    initial
    begin
        board         = new();
        board.clear();
        fail_count    = 0;
        quiet_cycles  = 0;
        send_idle_pct = 0;
        rst_n         = 1'b0;
        start         = 1'b0;
        op            = OP_READ;
        sector        = '0;
        foreach (sector_pool[i]) sector_pool[i] = $urandom;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty flush and reset, extreme sectors, hits, flush of dirty slots
        send_request(OP_FLUSH, '0);
        send_request(OP_RESET, '1);
        send_request(OP_READ, 32'h0000_0000);
        send_request(OP_WRITE, 32'hFFFF_FFFF);
        send_request(OP_READ, 32'hFFFF_FFFF);
        send_request(OP_WRITE, 32'h0000_0000);
        send_request(OP_READ, 32'hAAAA_AAAA);
        send_request(OP_WRITE, 32'h5555_5555);
        send_request(OP_FLUSH, 32'h1234_5678);
        send_request(OP_FLUSH, '0);
        send_request(OP_WRITE, 32'h8000_0001);
        send_request(OP_RESET, '0);
        // fill all slots with reads and writes, then misses evict clean and dirty lru victims
        for (int i = 0; i < SLOTS; i++)
            send_request(i % 3 == 0 ? OP_READ : OP_WRITE, 32'h100 + i);
        send_request(OP_READ, 32'h100 + 5);
        send_request(OP_WRITE, 32'hDEAD_BEEF);
        send_request(OP_READ, 32'hCAFE_F00D);
        send_request(OP_WRITE, 32'h0BAD_CAFE);
        send_request(OP_RESET, '0);

        random_phase(46, 29);
        random_phase(46, 49);
        random_phase(47, 0);

        // wait for outstanding transactions
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0 && board.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
design/sclru_pkg.sv
design/sclru_store.sv
design/sclru_ctrl.sv
design/sector_cache_lru_controller_core.sv
design/sclru_checker.sv
dv/tb.sv
